>>> src/ilc_pkg.sv
// ----------------------------------------------------------------------------
// ilc_pkg
// Shared request codes, datapath select codes and the command and status
// structs between the controller and the datapath of the indexed list.
// ----------------------------------------------------------------------------
package ilc_pkg;

   localparam int REQ_W = 3;
   localparam int INDEX_W = 8;
   localparam int ITEM_W = 32;
   localparam int COUNT_W = 9;

   // request codes
   localparam logic [REQ_W-1:0] REQ_APPEND = 3'd0;
   localparam logic [REQ_W-1:0] REQ_SET    = 3'd1;
   localparam logic [REQ_W-1:0] REQ_GET    = 3'd2;
   localparam logic [REQ_W-1:0] REQ_DELETE = 3'd3;
   localparam logic [REQ_W-1:0] REQ_POP    = 3'd4;
   localparam logic [REQ_W-1:0] REQ_TAIL   = 3'd5;

   // memory address sources
   localparam logic [1:0] ASEL_COUNT  = 2'd0;
   localparam logic [1:0] ASEL_INDEX  = 2'd1;
   localparam logic [1:0] ASEL_CURSOR = 2'd2;
   localparam logic [1:0] ASEL_TAIL   = 2'd3;

   typedef struct packed {
      logic       accept;
      logic       mem_we;
      logic [1:0] wr_sel;
      logic       wr_from_mem;
      logic       mem_re;
      logic [1:0] rd_sel;
      logic       cursor_step;
      logic       count_inc;
      logic       count_dec;
      logic       rsp_load;
      logic       rsp_ok;
      logic       rsp_has_data;
   } dp_cmd_type;

   typedef struct packed {
      logic in_range;
      logic empty;
      logic full;
      logic shift_more;
      logic rsp_free;
   } dp_status_type;

endpackage

>>> src/ilc_datapath.sv
// ----------------------------------------------------------------------------
// ilc_datapath
// Entry memory, occupancy count, shift cursor, read register and result
// register of the indexed list. Acts only on commands from the controller.
// ----------------------------------------------------------------------------
module ilc_datapath #(
   parameter int CAPACITY = 256,
   parameter int DATA_WIDTH = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   input  ilc_pkg::dp_cmd_type          cmd,
   output ilc_pkg::dp_status_type       status,
   input  logic [ilc_pkg::INDEX_W-1:0]  req_index,
   input  logic [ilc_pkg::ITEM_W-1:0]   req_item,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [ilc_pkg::ITEM_W-1:0]   rsp_data,
   output logic                         rsp_ok,
   output logic [ilc_pkg::COUNT_W-1:0]  rsp_count
);

   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int CMPW = (CW > ilc_pkg::INDEX_W) ? CW : ilc_pkg::INDEX_W;

   logic [DATA_WIDTH-1:0] mem [CAPACITY];

   logic [CW-1:0]               count_ff, count_in;
   logic [AW-1:0]               cursor_ff, cursor_in;
   logic [ilc_pkg::INDEX_W-1:0] index_ff;
   logic [DATA_WIDTH-1:0]       item_ff;
   logic [DATA_WIDTH-1:0]       rdata_ff;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [ilc_pkg::ITEM_W-1:0]  rsp_data_ff;
   logic                        rsp_ok_ff;
   logic [ilc_pkg::COUNT_W-1:0] rsp_count_ff;

   logic [CW-1:0]         tail;
   logic [CW-1:0]         cursor_next;
   logic [AW-1:0]         waddr, raddr;
   logic [DATA_WIDTH-1:0] wdata;

   assign tail        = count_ff - CW'(1);
   assign cursor_next = CW'(cursor_ff) + CW'(1);

   assign status.in_range   = CMPW'(index_ff) < CMPW'(count_ff);
   assign status.empty      = (count_ff == '0);
   assign status.full       = (count_ff == CW'(CAPACITY));
   assign status.shift_more = cursor_next < count_ff;
   assign status.rsp_free   = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      case (cmd.wr_sel)
         ilc_pkg::ASEL_COUNT:  waddr = count_ff[AW-1:0];
         ilc_pkg::ASEL_INDEX:  waddr = AW'(index_ff);
         ilc_pkg::ASEL_CURSOR: waddr = cursor_ff;
         default:              waddr = tail[AW-1:0];
      endcase
      case (cmd.rd_sel)
         ilc_pkg::ASEL_INDEX:  raddr = AW'(index_ff);
         ilc_pkg::ASEL_CURSOR: raddr = cursor_next[AW-1:0];
         ilc_pkg::ASEL_TAIL:   raddr = tail[AW-1:0];
         default:              raddr = count_ff[AW-1:0];
      endcase
      wdata = cmd.wr_from_mem ? rdata_ff : item_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.mem_we) begin
         mem[waddr] <= wdata;
      end
      if (cmd.mem_re) begin
         rdata_ff <= mem[raddr];
      end
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.count_inc) begin
         count_in = count_ff + CW'(1);
      end else if (cmd.count_dec) begin
         count_in = count_ff - CW'(1);
      end
      cursor_in = cursor_ff;
      if (cmd.accept) begin
         cursor_in = AW'(req_index);
      end else if (cmd.cursor_step) begin
         cursor_in = cursor_next[AW-1:0];
      end
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cursor_ff <= cursor_in;
      if (cmd.accept) begin
         index_ff <= req_index;
         item_ff  <= DATA_WIDTH'(req_item);
      end
      if (cmd.rsp_load) begin
         rsp_ok_ff    <= cmd.rsp_ok;
         rsp_data_ff  <= cmd.rsp_has_data ? ilc_pkg::ITEM_W'(rdata_ff) : '0;
         rsp_count_ff <= ilc_pkg::COUNT_W'(count_ff);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign rsp_ok    = rsp_ok_ff;
   assign rsp_count = rsp_count_ff;

endmodule

>>> src/ilc_ctrl.sv
// ----------------------------------------------------------------------------
// ilc_ctrl
// Controller of the indexed list: decodes a request, sequences memory reads,
// writes and the shift-down sweep of a delete, then loads the result.
// ----------------------------------------------------------------------------
module ilc_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [ilc_pkg::REQ_W-1:0]   req_type,
   input  ilc_pkg::dp_status_type      status,
   output ilc_pkg::dp_cmd_type         cmd
);

   localparam logic [2:0] ST_IDLE     = 3'd0;
   localparam logic [2:0] ST_DECODE   = 3'd1;
   localparam logic [2:0] ST_SHIFT_RD = 3'd2;
   localparam logic [2:0] ST_SHIFT_WR = 3'd3;
   localparam logic [2:0] ST_FINISH   = 3'd4;

   logic [2:0]                state_ff, state_in;
   logic [ilc_pkg::REQ_W-1:0] kind_ff, kind_in;
   logic                      ok_ff, ok_in;
   logic                      has_data_ff, has_data_in;

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in    = state_ff;
      kind_in     = kind_ff;
      ok_in       = ok_ff;
      has_data_in = has_data_ff;
      cmd              = '0;
      cmd.wr_sel       = ilc_pkg::ASEL_COUNT;
      cmd.rd_sel       = ilc_pkg::ASEL_INDEX;
      cmd.rsp_ok       = ok_ff;
      cmd.rsp_has_data = has_data_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               kind_in    = req_type;
               state_in   = ST_DECODE;
            end
         end
         ST_DECODE: begin
            ok_in       = 1'b0;
            has_data_in = 1'b0;
            state_in    = ST_FINISH;
            case (kind_ff)
               ilc_pkg::REQ_APPEND: begin
                  if (!status.full) begin
                     cmd.mem_we    = 1'b1;
                     cmd.wr_sel    = ilc_pkg::ASEL_COUNT;
                     cmd.count_inc = 1'b1;
                     ok_in         = 1'b1;
                  end
               end
               ilc_pkg::REQ_SET: begin
                  if (status.in_range) begin
                     cmd.mem_we = 1'b1;
                     cmd.wr_sel = ilc_pkg::ASEL_INDEX;
                     ok_in      = 1'b1;
                  end
               end
               ilc_pkg::REQ_GET: begin
                  if (status.in_range) begin
                     cmd.mem_re  = 1'b1;
                     cmd.rd_sel  = ilc_pkg::ASEL_INDEX;
                     ok_in       = 1'b1;
                     has_data_in = 1'b1;
                  end
               end
               ilc_pkg::REQ_DELETE: begin
                  if (status.in_range) begin
                     ok_in    = 1'b1;
                     state_in = ST_SHIFT_RD;
                  end
               end
               ilc_pkg::REQ_POP: begin
                  if (!status.empty) begin
                     cmd.mem_re    = 1'b1;
                     cmd.rd_sel    = ilc_pkg::ASEL_TAIL;
                     cmd.count_dec = 1'b1;
                     ok_in         = 1'b1;
                     has_data_in   = 1'b1;
                  end
               end
               ilc_pkg::REQ_TAIL: begin
                  if (!status.empty) begin
                     cmd.mem_re  = 1'b1;
                     cmd.rd_sel  = ilc_pkg::ASEL_TAIL;
                     ok_in       = 1'b1;
                     has_data_in = 1'b1;
                  end
               end
               default: begin
               end
            endcase
         end
         ST_SHIFT_RD: begin
            // fetch the entry above the cursor, or close the gap at the end
            if (status.shift_more) begin
               cmd.mem_re = 1'b1;
               cmd.rd_sel = ilc_pkg::ASEL_CURSOR;
               state_in   = ST_SHIFT_WR;
            end else begin
               cmd.count_dec = 1'b1;
               state_in      = ST_FINISH;
            end
         end
         ST_SHIFT_WR: begin
            cmd.mem_we      = 1'b1;
            cmd.wr_sel      = ilc_pkg::ASEL_CURSOR;
            cmd.wr_from_mem = 1'b1;
            cmd.cursor_step = 1'b1;
            state_in        = ST_SHIFT_RD;
         end
         ST_FINISH: begin
            if (status.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff     <= kind_in;
      ok_ff       <= ok_in;
      has_data_ff <= has_data_in;
   end

endmodule

>>> src/indexed_list_with_compaction.sv
// ----------------------------------------------------------------------------
// indexed_list_with_compaction
// Fixed-capacity ordered list of data words with append, set, get, delete
// with compaction, pop and tail read.
// ----------------------------------------------------------------------------
// One request is handled at a time. Append, set, get, pop, tail and refused
// requests pass through the decode and finish states before the next
// acceptance. A delete at index i of a list holding n entries moves each of
// the later entries down one place, a read then a write through the entry
// memory, then lowers the count to close the gap at the end of the list.
// The result register lets the next request be taken while a result waits;
// a request finishes only once the result register is free again. The entry
// memory needs no clearing after reset.
module indexed_list_with_compaction #(
   parameter int CAPACITY = 256,
   parameter int DATA_WIDTH = 32
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [ilc_pkg::REQ_W-1:0]   req_type,
   input  logic [ilc_pkg::INDEX_W-1:0] req_index,
   input  logic [ilc_pkg::ITEM_W-1:0]  req_item,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [ilc_pkg::ITEM_W-1:0]  rsp_data,
   output logic                        rsp_ok,
   output logic [ilc_pkg::COUNT_W-1:0] rsp_count
);

   ilc_pkg::dp_cmd_type    cmd;
   ilc_pkg::dp_status_type status;

   ilc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_type  (req_type),
      .status    (status),
      .cmd       (cmd)
   );

   ilc_datapath #(
      .CAPACITY   (CAPACITY),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_index (req_index),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .rsp_ok    (rsp_ok),
      .rsp_count (rsp_count)
   );

endmodule
